@@ rtl/snd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 2D simplex noise block.
`timescale 1ns / 1ps
`default_nettype none
package snd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned Latency  = 21;

  typedef enum logic [0:0] {
    REG_FREQUENCY = 1'b0
  } cfg_reg_t;

  localparam logic signed [31:0] FREQ_RESET = 32'sd1310720;

  localparam logic signed [23:0] K_F2    = 24'sd6140887;
  localparam logic signed [22:0] K_G2    = 23'sd3545443;
  localparam logic signed [47:0] Q24_ONE = 48'sd16777216;
  localparam logic signed [50:0] M48_TOP = 51'sd140737488355328;

  localparam logic [17:0] MOD_OFS = 18'd131206;
  localparam logic [15:0] INV289  = 16'd58052;
  localparam logic [10:0] INV41   = 11'd1598;

  localparam logic signed [33:0] Z_MIN = -34'sd10747904;
  localparam logic signed [33:0] Z_MAX = 34'sd10747903;
  localparam logic [24:0] Z_OFS   = 25'd10747904;
  localparam logic [24:0] INV82   = 25'd26188825;
  localparam logic [18:0] OUT_OFS = 19'd131072;

  typedef struct packed {
    logic [8:0]         hash;
    logic signed [47:0] dx;
    logic signed [47:0] dy;
  } corner_t;

  typedef logic signed [7:0] grad_tab_t [0:40];
  typedef logic [24:0]       norm_tab_t [0:40];

  function automatic grad_tab_t calc_a_tab();
    grad_tab_t tab;
    int x82;
    int t;
    int ox;
    for (int r = 0; r < 41; r++) begin
      x82 = 4 * r - 82;
      t   = 4 * r - 41;
      ox  = (t < 0) ? -1 : ((t >= 82) ? 1 : 0);
      tab[r] = 8'(x82 - 82 * ox);
    end
    return tab;
  endfunction

  function automatic grad_tab_t calc_h_tab();
    grad_tab_t tab;
    int x82;
    for (int r = 0; r < 41; r++) begin
      x82 = 4 * r - 82;
      tab[r] = 8'(((x82 < 0) ? -x82 : x82) - 41);
    end
    return tab;
  endfunction

  function automatic norm_tab_t calc_norm_tab();
    norm_tab_t tab;
    longint x82;
    longint t;
    longint ox;
    longint a;
    longint h;
    for (int r = 0; r < 41; r++) begin
      x82 = 4 * r - 82;
      t   = 4 * r - 41;
      ox  = (t < 0) ? -1 : ((t >= 82) ? 1 : 0);
      a   = x82 - 82 * ox;
      h   = ((x82 < 0) ? -x82 : x82) - 41;
      tab[r] = 25'(64'sd30078913 - (64'sd14323292 * (a * a + h * h)) / 6724);
    end
    return tab;
  endfunction

  localparam grad_tab_t A_TAB    = calc_a_tab();
  localparam grad_tab_t H_TAB    = calc_h_tab();
  localparam norm_tab_t NORM_TAB = calc_norm_tab();

  // reciprocal estimate is exact or one low for w < 2^24
  function automatic logic [8:0] mod289(input logic [23:0] w);
    logic [39:0] prod;
    logic [15:0] q;
    logic [23:0] r;
    prod = 40'(w) * 40'(INV289);
    q    = prod[39:24];
    r    = w - 24'(25'(q) * 25'd289);
    return (r >= 24'd289) ? 9'(r - 24'd289) : 9'(r);
  endfunction

  function automatic logic [5:0] mod41(input logic [8:0] h);
    logic [19:0] prod;
    logic [3:0]  q;
    logic [8:0]  r;
    prod = 20'(h) * 20'(INV41);
    q    = prod[19:16];
    r    = h - 9'(10'(q) * 10'd41);
    return (r >= 9'd41) ? 6'(r - 9'd41) : 6'(r);
  endfunction

  // (34v + 1) * v, reduced mod 289 in the next stage
  function automatic logic [23:0] perm_pre(input logic [9:0] v);
    logic [15:0] a;
    a = 16'(v) * 16'd34 + 16'd1;
    return 24'(a) * 24'(v);
  endfunction

endpackage
`default_nettype wire

@@ rtl/simplex_noise_2d.sv @@
// Top level of the 2D simplex noise block: config registers, pipeline and result strobe.
`timescale 1ns / 1ps
`default_nettype none
// Fully pipelined: one point is taken every clock (busy is always low) and its
// noise value appears on out_noise_value with out_valid. The pipeline chains the
// coordinate/hash pipeline (10 stages), the per-corner falloff pipeline (7 stages,
// three corners in parallel) and the scale/saturate tail (4 stages). Results
// cannot be held off; each is valid for one cycle only. Write the frequency
// register only while no point is in flight.
module simplex_noise_2d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_seed,
  output logic                          out_valid,
  output logic signed [17:0]            out_noise_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [snd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic signed [31:0] freq_r;
  logic               freq_sel;
  logic               front_vld;
  snd_pkg::corner_t   crn [3];
  logic [2:0]         crn_vld;
  logic signed [55:0] contrib [3];

  assign freq_sel = paddr[snd_pkg::CfgAddrW-1:2] == snd_pkg::REG_FREQUENCY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= snd_pkg::FREQ_RESET;
    end else if (psel && penable && pwrite && freq_sel) begin
      freq_r <= pwdata;
    end
  end

  assign prdata = freq_sel ? freq_r : 32'd0;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  snd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .seed    (in_seed),
    .freq    (freq_r),
    .out_vld (front_vld),
    .crn     (crn)
  );

  for (genvar i = 0; i < 3; i++) begin : g_corner
    snd_corner u_corner (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (front_vld),
      .crn     (crn[i]),
      .out_vld (crn_vld[i]),
      .contrib (contrib[i])
    );
  end

  snd_final u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (&crn_vld),
    .c0      (contrib[0]),
    .c1      (contrib[1]),
    .c2      (contrib[2]),
    .out_vld (out_valid),
    .noise   (out_noise_value)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##21 out_valid)
    else $error("result strobe missing after start beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, snd_pkg::Latency))
    else $error("result strobe without matching start beat");

  a_freq_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && freq_sel |=> freq_r == $past(pwdata))
    else $error("frequency register write lost");

  a_freq_reset: assert property (@(posedge clk)
    !rst_n |=> freq_r == snd_pkg::FREQ_RESET)
    else $error("frequency register not at reset value");
`endif

endmodule
`default_nettype wire

@@ rtl/snd_front.sv @@
// Coordinate pipeline: fractions, scaling, skew, cell selection and corner hashes.
`timescale 1ns / 1ps
`default_nettype none
module snd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] seed,
  input  logic signed [31:0] freq,
  output logic               out_vld,
  output snd_pkg::corner_t   crn [3]
);

  localparam logic signed [23:0] K_F2_EXT = snd_pkg::K_F2;

  logic [9:0] vld_r;

  logic [15:0]        magx, magy;
  logic signed [16:0] fx, fy;
  logic signed [16:0] fx1_r;
  logic signed [48:0] p1_r;

  logic signed [48:0] pa;
  logic [15:0]        pmag;
  logic signed [16:0] fx2_r, fy2_r;

  logic signed [48:0] vpx, vpy;
  logic signed [40:0] vx3_r, vy3_r;

  logic signed [41:0] vsum;
  logic signed [65:0] sp;
  logic signed [40:0] vx4_r, vy4_r;
  logic signed [41:0] s4_r;

  logic signed [42:0] ax, ay;
  logic signed [40:0] vx5_r, vy5_r;
  logic signed [18:0] ix5_r, iy5_r;

  logic signed [19:0] ijs;
  logic signed [42:0] ij6_r;
  logic signed [47:0] dxp6_r, dyp6_r;
  logic [8:0]         mx6_r, my6_r;

  logic signed [47:0] x0x7_r, x0y7_r;
  logic [23:0]        t07_r, t17_r;
  logic [8:0]         mx7_r;

  logic signed [47:0] x0x8_r, x0y8_r;
  logic [8:0]         pm08_r, pm18_r, mx8_r;
  logic               i1x8_r;

  logic [9:0]         vh0, vh1, vh2;
  logic [23:0]        th9_r [3];
  logic signed [47:0] dx9_r [3];
  logic signed [47:0] dy9_r [3];

  snd_pkg::corner_t   crn10_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[8:0], in_vld};
    end
  end

  always_comb begin
    magx = pos_x[31] ? 16'(-pos_x) : pos_x[15:0];
    magy = pos_y[31] ? 16'(-pos_y) : pos_y[15:0];
    fx   = pos_x[31] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    fy   = pos_y[31] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    pa   = p1_r[48] ? -p1_r : p1_r;
    pmag = pa[31:16];
    vpx  = 49'(fx2_r) * 49'(freq);
    vpy  = 49'(fy2_r) * 49'(freq);
    vsum = 42'(vx3_r) + 42'(vy3_r);
    sp   = 66'(vsum) * 66'(K_F2_EXT);
    ax   = 43'(vx4_r) + 43'(s4_r);
    ay   = 43'(vy4_r) + 43'(s4_r);
    ijs  = 20'(ix5_r) + 20'(iy5_r);
    vh0  = 10'(pm08_r) + 10'(mx8_r);
    vh1  = 10'(i1x8_r ? pm08_r : pm18_r) + 10'(mx8_r) + 10'(i1x8_r);
    vh2  = 10'(pm18_r) + 10'(mx8_r) + 10'd1;
  end

  always_ff @(posedge clk) begin
    fx1_r  <= fx;
    p1_r   <= 49'(fy) * 49'(seed);

    fx2_r  <= fx1_r;
    fy2_r  <= p1_r[48] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

    vx3_r  <= vpx[48:8];
    vy3_r  <= vpy[48:8];

    vx4_r  <= vx3_r;
    vy4_r  <= vy3_r;
    s4_r   <= sp[65:24];

    vx5_r  <= vx4_r;
    vy5_r  <= vy4_r;
    ix5_r  <= ax[42:24];
    iy5_r  <= ay[42:24];

    ij6_r  <= 43'(ijs) * 43'(snd_pkg::K_G2);
    dxp6_r <= 48'(vx5_r) - (48'(ix5_r) <<< 24);
    dyp6_r <= 48'(vy5_r) - (48'(iy5_r) <<< 24);
    mx6_r  <= snd_pkg::mod289(24'(ix5_r) + 24'(snd_pkg::MOD_OFS));
    my6_r  <= snd_pkg::mod289(24'(iy5_r) + 24'(snd_pkg::MOD_OFS));

    x0x7_r <= dxp6_r + 48'(ij6_r);
    x0y7_r <= dyp6_r + 48'(ij6_r);
    t07_r  <= snd_pkg::perm_pre(10'(my6_r));
    t17_r  <= snd_pkg::perm_pre(10'(my6_r) + 10'd1);
    mx7_r  <= mx6_r;

    x0x8_r <= x0x7_r;
    x0y8_r <= x0y7_r;
    pm08_r <= snd_pkg::mod289(t07_r);
    pm18_r <= snd_pkg::mod289(t17_r);
    mx8_r  <= mx7_r;
    i1x8_r <= x0x7_r > x0y7_r;

    th9_r[0] <= snd_pkg::perm_pre(vh0);
    th9_r[1] <= snd_pkg::perm_pre(vh1);
    th9_r[2] <= snd_pkg::perm_pre(vh2);
    dx9_r[0] <= x0x8_r;
    dy9_r[0] <= x0y8_r;
    dx9_r[1] <= x0x8_r + 48'(snd_pkg::K_G2) - (i1x8_r ? snd_pkg::Q24_ONE : 48'sd0);
    dy9_r[1] <= x0y8_r + 48'(snd_pkg::K_G2) - (i1x8_r ? 48'sd0 : snd_pkg::Q24_ONE);
    dx9_r[2] <= x0x8_r + 48'(snd_pkg::K_G2) + 48'(snd_pkg::K_G2) - snd_pkg::Q24_ONE;
    dy9_r[2] <= x0y8_r + 48'(snd_pkg::K_G2) + 48'(snd_pkg::K_G2) - snd_pkg::Q24_ONE;

    for (int i = 0; i < 3; i++) begin
      crn10_r[i].hash <= snd_pkg::mod289(th9_r[i]);
      crn10_r[i].dx   <= dx9_r[i];
      crn10_r[i].dy   <= dy9_r[i];
    end
  end

  assign out_vld = vld_r[9];
  assign crn     = crn10_r;

endmodule
`default_nettype wire

@@ rtl/snd_corner.sv @@
// One simplex corner: gradient lookup, fourth-power falloff and weighted contribution.
`timescale 1ns / 1ps
`default_nettype none
module snd_corner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  snd_pkg::corner_t   crn,
  output logic               out_vld,
  output logic signed [55:0] contrib
);

  logic [6:0] vld_r;

  logic               fitx, fity;
  logic [5:0]         r1_r;
  logic signed [24:0] dx1_r, dy1_r;
  logic               small1_r;

  logic signed [49:0] sqx, sqy;
  logic signed [50:0] sq2_r;
  logic signed [33:0] gx2_r, gy2_r;
  logic [24:0]        norm2_r;
  logic               small2_r;

  logic signed [50:0] m48;
  logic [23:0]        m3_r;
  logic signed [34:0] g3_r;
  logic [24:0]        norm3_r;

  logic [47:0]        mm;
  logic [22:0]        m24_r;
  logic signed [34:0] g4_r;
  logic [24:0]        norm4_r;

  logic [45:0]        m4p;
  logic [20:0]        m45_r;
  logic signed [34:0] g5_r;
  logic [24:0]        norm5_r;

  logic [45:0]        mnp;
  logic [21:0]        mn6_r;
  logic signed [34:0] g6_r;

  logic signed [55:0] c7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_comb begin
    fitx = crn.dx[47:24] == {24{crn.dx[24]}};
    fity = crn.dy[47:24] == {24{crn.dy[24]}};
    sqx  = 50'(dx1_r) * 50'(dx1_r);
    sqy  = 50'(dy1_r) * 50'(dy1_r);
    m48  = snd_pkg::M48_TOP - sq2_r;
    mm   = 48'(m3_r) * 48'(m3_r);
    m4p  = 46'(m24_r) * 46'(m24_r);
    mnp  = 46'(m45_r) * 46'(norm5_r);
  end

  always_ff @(posedge clk) begin
    r1_r     <= snd_pkg::mod41(crn.hash);
    dx1_r    <= crn.dx[24:0];
    dy1_r    <= crn.dy[24:0];
    small1_r <= fitx & fity;

    sq2_r    <= 51'(sqx) + 51'(sqy);
    gx2_r    <= 34'(snd_pkg::A_TAB[r1_r]) * 34'(dx1_r);
    gy2_r    <= 34'(snd_pkg::H_TAB[r1_r]) * 34'(dy1_r);
    norm2_r  <= snd_pkg::NORM_TAB[r1_r];
    small2_r <= small1_r;

    m3_r     <= (small2_r && !m48[50]) ? m48[47:24] : 24'd0;
    g3_r     <= 35'(gx2_r) + 35'(gy2_r);
    norm3_r  <= norm2_r;

    m24_r    <= mm[46:24];
    g4_r     <= g3_r;
    norm4_r  <= norm3_r;

    m45_r    <= m4p[44:24];
    g5_r     <= g4_r;
    norm5_r  <= norm4_r;

    mn6_r    <= mnp[45:24];
    g6_r     <= g5_r;

    c7_r     <= 56'($signed({1'b0, mn6_r})) * 56'(g6_r);
  end

  assign out_vld = vld_r[6];
  assign contrib = c7_r;

endmodule
`default_nettype wire

@@ rtl/snd_final.sv @@
// Sum of corner contributions, scale by 130/82, saturation to Q2.16.
`timescale 1ns / 1ps
`default_nettype none
module snd_final (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [55:0] c0,
  input  logic signed [55:0] c1,
  input  logic signed [55:0] c2,
  output logic               out_vld,
  output logic signed [17:0] noise
);

  logic [3:0] vld_r;

  logic signed [57:0] sum1_r;
  logic signed [41:0] t;
  logic signed [49:0] zp;
  logic signed [33:0] z2_r;
  logic signed [33:0] zc;
  logic [24:0]        u3_r;
  logic [49:0]        qp;
  logic [18:0]        q;
  logic signed [17:0] noise4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_comb begin
    t  = sum1_r[57:16];
    zp = 50'(t) * 50'sd130;
    priority if (z2_r > snd_pkg::Z_MAX) begin
      zc = snd_pkg::Z_MAX;
    end else if (z2_r < snd_pkg::Z_MIN) begin
      zc = snd_pkg::Z_MIN;
    end else begin
      zc = z2_r;
    end
    qp = 50'(u3_r) * 50'(snd_pkg::INV82);
    q  = qp[49:31];
  end

  always_ff @(posedge clk) begin
    sum1_r   <= 58'(c0) + 58'(c1) + 58'(c2);
    z2_r     <= zp[49:16];
    u3_r     <= 25'(zc) + snd_pkg::Z_OFS;
    noise4_r <= 18'(q - snd_pkg::OUT_OFS);
  end

  assign out_vld = vld_r[3];
  assign noise   = noise4_r;

endmodule
`default_nettype wire

@@ test/snd_checker.sv @@
// Checker for the 2D simplex noise block: predicts each noise value and compares results.
`timescale 1ns / 1ps
`default_nettype none
module snd_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_seed,
  input  wire logic               out_valid,
  input  wire logic signed [17:0] out_noise_value,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [snd_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending_noise
);

  localparam longint ONE24 = 64'sd16777216;

  longint freq_q16;
  logic signed [17:0] noise_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap289(longint v);
    longint r;
    r = v % 289;
    return (r < 0) ? r + 289 : r;
  endfunction

  function automatic longint hash289(longint v);
    return wrap289((34 * v + 1) * v);
  endfunction

  function automatic longint corner_term(longint hash, longint dx, longint dy);
    longint r, x82, h82, t, ox, a82, norm, m48, m, m2, m4, mn;
    r    = hash % 41;
    x82  = 4 * r - 82;
    h82  = ((x82 < 0) ? -x82 : x82) - 41;
    t    = 4 * r - 41;
    ox   = (t < 0) ? -1 : ((t >= 82) ? 1 : 0);
    a82  = x82 - 82 * ox;
    norm = 64'sd30078913 - (64'sd14323292 * (a82 * a82 + h82 * h82)) / 6724;
    m48  = ONE24 * ONE24 / 2 - (dx * dx + dy * dy);
    if (m48 < 0) m48 = 0;
    m  = floor_shift(m48, 24);
    m2 = floor_shift(m * m, 24);
    m4 = floor_shift(m2 * m2, 24);
    mn = floor_shift(m4 * norm, 24);
    return mn * (a82 * dx + h82 * dy);
  endfunction

  function automatic logic signed [17:0] predict_noise(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] sd, longint fr);
    longint fx, fy, p, mag, vx, vy, s, ix, iy, ij, x0x, x0y, i1x, i1y;
    longint mx, my, hx, hy, hz, sum, q, res, den;
    fx  = (px < 0) ? -((-longint'(px)) & 64'hFFFF) : (longint'(px) & 64'hFFFF);
    fy  = (py < 0) ? -((-longint'(py)) & 64'hFFFF) : (longint'(py) & 64'hFFFF);
    p   = fy * longint'(sd);
    mag = (((p < 0) ? -p : p) & 64'hFFFFFFFF) >> 16;
    fy  = (p < 0) ? -mag : mag;
    vx  = floor_shift(fx * fr, 8);
    vy  = floor_shift(fy * fr, 8);
    s   = floor_shift((vx + vy) * 64'sd6140887, 24);
    ix  = floor_shift(vx + s, 24);
    iy  = floor_shift(vy + s, 24);
    ij  = (ix + iy) * 64'sd3545443;
    x0x = vx - ix * ONE24 + ij;
    x0y = vy - iy * ONE24 + ij;
    if (x0x > x0y) begin
      i1x = 1; i1y = 0;
    end else begin
      i1x = 0; i1y = 1;
    end
    mx  = wrap289(ix);
    my  = wrap289(iy);
    hx  = hash289(hash289(my) + mx);
    hy  = hash289(hash289(my + i1y) + mx + i1x);
    hz  = hash289(hash289(my + 1) + mx + 1);
    sum = corner_term(hx, x0x, x0y)
        + corner_term(hy, x0x + 64'sd3545443 - i1x * ONE24, x0y + 64'sd3545443 - i1y * ONE24)
        + corner_term(hz, x0x + 2 * 64'sd3545443 - ONE24, x0y + 2 * 64'sd3545443 - ONE24);
    q   = floor_shift(sum, 16) * 130;
    den = 82 * 65536;
    res = q / den;
    if ((q % den) != 0 && q < 0) res = res - 1;
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return 18'(res);
  endfunction

  assign pending_noise = noise_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      freq_q16 <= longint'(snd_pkg::FREQ_RESET);
      noise_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected beat, actual %0d", out_noise_value);
          fail_count <= fail_count + 1;
        end else begin
          if (noise_q[0] !== out_noise_value) begin
            $error("noise_value: expected %0d, actual %0d", noise_q[0], out_noise_value);
            fail_count <= fail_count + 1;
          end
          void'(noise_q.pop_front());
        end
      end
      if (start && !busy)
        noise_q.push_back(predict_noise(in_pos_x, in_pos_y, in_seed, freq_q16));
      if (psel && penable && pwrite && pready &&
          paddr == snd_pkg::CfgAddrW'(snd_pkg::REG_FREQUENCY) * 4)
        freq_q16 <= longint'(signed'(pwdata));
    end
  end
endmodule
`default_nettype wire

@@ test/tb_simplex_noise_2d.sv @@
// Testbench top for the 2D simplex noise block: stimulus, register writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_simplex_noise_2d;

  localparam int WatchdogLimit = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_seed = '0;
  logic out_valid;
  logic signed [17:0] out_noise_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [snd_pkg::CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending_noise;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  simplex_noise_2d i_dut (.*);
  snd_checker i_checker (.*);

  always @(posedge clk) begin
    if (out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] s);
    while (!calm && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_seed <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_points();
    start <= 1'b0;
    @(posedge clk);
    while (pending_noise != 0) @(posedge clk);
    repeat (snd_pkg::Latency + 4) @(posedge clk);
  endtask

  task automatic write_frequency(logic [31:0] v);
    drain_points();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= snd_pkg::CfgAddrW'(snd_pkg::REG_FREQUENCY) * 4; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($urandom_range(65535)) ^ {32{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] freqs [0:6];
    freqs = '{32'h0014_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
              32'hFFEC_0000, 32'h0001_0000, 32'h0640_0000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm = 1'b1;
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0001_0000);
    send_point(32'hFFFF_0001, 32'h0000_8000, 32'h8000_0000);
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
    send_point(32'h0001_2345, 32'h0001_2345, 32'h0001_0000);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0002_0000);
    calm = 1'b0;
    for (int k = 0; k < 7; k++) begin
      write_frequency(freqs[k]);
      calm = (k == 2);
      for (int n = 0; n < 105; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (n == 50) drain_points();
      end
      calm = 1'b0;
    end
    write_frequency($urandom);
    for (int n = 0; n < 20; n++) send_point(rand_coord(), rand_coord(), $urandom);
    drain_points();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/snd_pkg.sv
rtl/snd_front.sv
rtl/snd_corner.sv
rtl/snd_final.sv
rtl/simplex_noise_2d.sv
test/snd_checker.sv
test/tb_simplex_noise_2d.sv
